// ===== hdl/rsaexp_pkg.sv =====
package rsaexp_pkg;

    // widths of the stream fields
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned IN_W    = 3 * FIELD_W;
    localparam int unsigned D_W     = 64;

    // result status codes
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NO_INVERSE = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_MOD    = 6'b000100,
        ST_SEARCH = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage

// ===== hdl/rsa_private_exponent_search_top.sv =====
// channel  | direction | fields (low bit first)                          | handshake
// s_*      | in        | tdata: prime_p, prime_q, exponent_e              | tvalid/tready
// m_*      | out       | tdata: exponent_d; tuser: status                 | tvalid/tready
//
// one item at a time: accept, multiply, an NW-bit mod by e, the search, an NW-bit
// divide by e, then finish, with NW = EXPONENT_WIDTH + 2*PRIME_WIDTH; a zero e
// skips straight to finish, and so does a search that finds no inverse
// the search tests one candidate per cycle on its own modular adder; the
// restoring divider does one quotient bit per cycle
// rst_n clears the sequencer and the output valid; no clearing pass
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next item is taken while it is still pending
module rsa_private_exponent_search_top #(
    parameter int unsigned PRIME_WIDTH    = 32,
    parameter int unsigned EXPONENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rsaexp_pkg::IN_W-1:0]       s_tdata,   // prime_p, prime_q, exponent_e
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsaexp_pkg::D_W-1:0]        m_tdata,   // exponent_d
    output logic                              m_tuser    // status
);

    localparam int unsigned PW  = PRIME_WIDTH;
    localparam int unsigned EW  = EXPONENT_WIDTH;
    localparam int unsigned PHW = 2 * PW;
    localparam int unsigned NW  = EW + PHW;
    localparam int unsigned CW  = $clog2(NW + 1);
    localparam int unsigned FW  = rsaexp_pkg::FIELD_W;
    localparam int unsigned DW  = rsaexp_pkg::D_W;

    rsaexp_pkg::state_t state_reg, state_next;

    logic [PW-1:0]  pm1_reg, pm1_next;
    logic [PW-1:0]  qm1_reg, qm1_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [PHW-1:0] phi_reg, phi_next;
    logic [EW-1:0]  rm_reg, rm_next;      // phi mod e
    logic [EW-1:0]  r_reg, r_next;        // x*phi mod e
    logic [EW-1:0]  x_reg, x_next;
    logic [NW-1:0]  acc_reg, acc_next;    // x*phi
    logic [NW-1:0]  dvd_reg, dvd_next;    // dividend, quotient shifts in
    logic [EW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           fail_reg, fail_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [rsaexp_pkg::D_W-1:0] d_reg, d_next;
    logic                       st_reg, st_next;

    logic           in_xfer;
    logic           out_free;
    logic [EW:0]    trial;
    logic           trial_ge;
    logic [EW:0]    trial_diff;
    logic [EW:0]    msum;
    logic           msum_ge;
    logic [EW:0]    msum_diff;
    logic           hit;
    logic           last_x;
    logic           last_step;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == rsaexp_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = d_reg;
    assign m_tuser  = st_reg;

    // restoring divide step: one quotient bit
    assign trial      = {rem_reg, dvd_reg[NW-1]};
    assign trial_ge   = (trial >= {1'b0, e_reg});
    assign trial_diff = trial - {1'b0, e_reg};
    assign last_step  = (cnt_reg == CW'(1));

    // modular add for the next candidate
    assign msum      = {1'b0, r_reg} + {1'b0, rm_reg};
    assign msum_ge   = (msum >= {1'b0, e_reg});
    assign msum_diff = msum - {1'b0, e_reg};
    assign hit       = (r_reg == e_reg - EW'(1));
    assign last_x    = (x_reg == e_reg - EW'(1));

    // sequencer and datapath
    always_comb
    begin
        state_next    = state_reg;
        pm1_next      = pm1_reg;
        qm1_next      = qm1_reg;
        e_next        = e_reg;
        phi_next      = phi_reg;
        rm_next       = rm_reg;
        r_next        = r_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        fail_next     = fail_reg;
        m_tvalid_next = m_tvalid_reg;
        d_next        = d_reg;
        st_next       = st_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            rsaexp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    pm1_next   = s_tdata[PW-1:0] - PW'(1);
                    qm1_next   = s_tdata[FW +: PW] - PW'(1);
                    e_next     = s_tdata[2*FW +: EW];
                    state_next = rsaexp_pkg::ST_MUL;
                end
            end
            rsaexp_pkg::ST_MUL:
            begin
                phi_next  = PHW'(pm1_reg) * PHW'(qm1_reg);
                dvd_next  = NW'(phi_next);
                rem_next  = '0;
                cnt_next  = CW'(NW);
                fail_next = (e_reg == '0);
                if (e_reg == '0)
                begin
                    state_next = rsaexp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = rsaexp_pkg::ST_MOD;
                end
            end
            rsaexp_pkg::ST_MOD:
            begin
                rem_next = trial_ge ? trial_diff[EW-1:0] : trial[EW-1:0];
                dvd_next = {dvd_reg[NW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
                if (last_step)
                begin
                    rm_next    = rem_next;
                    r_next     = rem_next;
                    x_next     = EW'(1);
                    acc_next   = NW'(phi_reg);
                    state_next = rsaexp_pkg::ST_SEARCH;
                end
            end
            rsaexp_pkg::ST_SEARCH:
            begin
                priority if (hit)
                begin
                    dvd_next   = acc_reg + NW'(1);
                    rem_next   = '0;
                    cnt_next   = CW'(NW);
                    state_next = rsaexp_pkg::ST_DIV;
                end
                else if (last_x)
                begin
                    fail_next  = 1'b1;
                    state_next = rsaexp_pkg::ST_FINISH;
                end
                else
                begin
                    x_next   = x_reg + EW'(1);
                    r_next   = msum_ge ? msum_diff[EW-1:0] : msum[EW-1:0];
                    acc_next = acc_reg + NW'(phi_reg);
                end
            end
            rsaexp_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? trial_diff[EW-1:0] : trial[EW-1:0];
                dvd_next = {dvd_reg[NW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
                if (last_step)
                begin
                    state_next = rsaexp_pkg::ST_FINISH;
                end
            end
            rsaexp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (fail_reg)
                    begin
                        d_next  = '0;
                        st_next = rsaexp_pkg::STATUS_NO_INVERSE;
                    end
                    else
                    begin
                        d_next  = DW'(dvd_reg[PHW-1:0]);
                        st_next = rsaexp_pkg::STATUS_OK;
                    end
                    state_next = rsaexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsaexp_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rsaexp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            fail_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            fail_reg     <= fail_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pm1_reg <= pm1_next;
        qm1_reg <= qm1_next;
        e_reg   <= e_next;
        phi_reg <= phi_next;
        rm_reg  <= rm_next;
        r_reg   <= r_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        st_reg  <= st_next;
    end

    // no-inverse results carry a zero exponent
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("no-inverse result with nonzero exponent");

    // search residue stays reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsaexp_pkg::ST_SEARCH) |-> (r_reg < e_reg))
        else $error("search residue not below exponent");

    // divide step counter stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rsaexp_pkg::ST_MOD) || (state_reg == rsaexp_pkg::ST_DIV))
        |-> ((cnt_reg != '0) && (cnt_reg <= CW'(NW))))
        else $error("divide counter out of range");

    // leaving finish always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rsaexp_pkg::ST_FINISH) && out_free) |=> m_tvalid)
        else $error("finished item not presented");

    // a zero exponent never reaches the search
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rsaexp_pkg::ST_MUL) && (e_reg == '0))
        |=> (state_reg == rsaexp_pkg::ST_FINISH))
        else $error("zero exponent entered the search");

endmodule

// ===== tb/sv/tb_rsa_private_exponent_search_top.sv =====
module tb_rsa_private_exponent_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FIELD_W = rsaexp_pkg::FIELD_W;
    localparam int unsigned IN_W    = rsaexp_pkg::IN_W;
    localparam int unsigned D_W     = rsaexp_pkg::D_W;

    // cycles with no transfer on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 400000;

    typedef struct packed {
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] prime_q;
        logic [FIELD_W-1:0] prime_p;
    } key_request_t;

    typedef struct {
        logic [D_W-1:0] d;
        logic           status;
    } key_result_t;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [D_W-1:0]    m_tdata;
    logic              m_tuser;

    key_result_t       expected_keys[$];
    int unsigned       mismatch_count = 0;
    bit                sender_gaps    = 1'b1;
    bit                receiver_gaps  = 1'b1;
    int unsigned       hold_request   = 0;

    rsa_private_exponent_search_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // extended euclid; returns 0 when value and modulus share a factor
    function automatic bit invert_mod(input longint unsigned value,
                                      input longint unsigned modulus,
                                      output longint unsigned inverse);
        longint unsigned g_prev;
        longint unsigned g_cur;
        longint unsigned quo;
        longint unsigned g_next;
        longint          s_prev;
        longint          s_cur;
        longint          s_next;
        g_prev  = modulus;
        g_cur   = value % modulus;
        s_prev  = 0;
        s_cur   = 1;
        inverse = 0;
        while (g_cur != 0)
        begin
            quo    = g_prev / g_cur;
            g_next = g_prev - quo * g_cur;
            s_next = s_prev - longint'(quo) * s_cur;
            g_prev = g_cur;
            g_cur  = g_next;
            s_prev = s_cur;
            s_cur  = s_next;
        end
        if (g_prev != 1)
            return 1'b0;
        if (s_prev < 0)
            s_prev += longint'(modulus);
        inverse = longint'(s_prev);
        return 1'b1;
    endfunction

    // expected d and status for one key request
    function automatic key_result_t predict_key(input key_request_t req);
        logic [FIELD_W-1:0] pm1;
        logic [FIELD_W-1:0] qm1;
        logic [63:0]        phi;
        longint unsigned    e;
        longint unsigned    inv;
        longint unsigned    mult;
        logic [127:0]       numer;
        key_result_t        res;
        res.d      = '0;
        res.status = rsaexp_pkg::STATUS_OK;
        e   = req.exponent;
        pm1 = req.prime_p - 1'b1;
        qm1 = req.prime_q - 1'b1;
        phi = 64'(pm1) * 64'(qm1);
        if (e == 0)
        begin
            res.status = rsaexp_pkg::STATUS_NO_INVERSE;
            return res;
        end
        if (e == 1)
            mult = 1;
        else if (!invert_mod(phi % e, e, inv))
        begin
            res.status = rsaexp_pkg::STATUS_NO_INVERSE;
            return res;
        end
        else
            mult = e - inv;
        numer = 128'(mult) * 128'(phi) + 128'd1;
        res.d = 64'(numer / 128'(e));
        return res;
    endfunction

    function automatic key_request_t make_key(input logic [FIELD_W-1:0] p,
                                              input logic [FIELD_W-1:0] q,
                                              input logic [FIELD_W-1:0] e);
        key_request_t req;
        req.prime_p  = p;
        req.prime_q  = q;
        req.exponent = e;
        return req;
    endfunction

    // choose q so that the search for a large e stops at multiplier x
    function automatic key_request_t build_key(input logic [FIELD_W-1:0] e,
                                               input logic [FIELD_W-1:0] x_want,
                                               input logic [FIELD_W-1:0] p);
        logic [FIELD_W-1:0] pm1;
        longint unsigned    ee;
        longint unsigned    x;
        longint unsigned    inv_x;
        longint unsigned    target;
        longint unsigned    inv_a;
        longint unsigned    b;
        longint unsigned    kmax;
        longint unsigned    k;
        ee = e;
        x  = x_want % ee;
        if (x == 0)
            x = 1;
        if (!invert_mod(x, ee, inv_x))
        begin
            x     = 1;
            inv_x = 1;
        end
        // phi must be congruent to -1/x
        target = (ee - inv_x) % ee;
        pm1    = p - 1'b1;
        if (!invert_mod(pm1, ee, inv_a))
        begin
            p     = 2;
            inv_a = 1;
        end
        b    = (target * inv_a) % ee;
        kmax = (64'hFFFF_FFFF - b) / ee;
        k    = {$urandom, $urandom} % (kmax + 1);
        return make_key(p, FIELD_W'(b + k * ee + 1), e);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_prime();
        if ($urandom_range(9) == 0)
        begin
            unique case ($urandom_range(3))
                0: return '0;
                1: return 1;
                2: return 2;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [D_W-1:0] got,
                                   input logic [D_W-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // offer one request and record its expected result on transfer
    task automatic offer_key(input key_request_t req);
        while (sender_gaps && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        expected_keys.push_back(predict_key(req));
    endtask

    task automatic wait_for_results();
        while (expected_keys.size() != 0)
            @(posedge clk);
    endtask

    // zero and one primes, exponents zero, one and two, shared factors, largest e
    task automatic test_corner_keys();
        offer_key(make_key(61, 53, 17));
        offer_key(make_key(3, 11, 3));
        offer_key(make_key(0, 0, 3));
        offer_key(make_key(0, 0, 7));
        offer_key(make_key(1, 5, 5));
        offer_key(make_key(1, 1, 1));
        offer_key(make_key('1, '1, 1));
        offer_key(make_key(61, 53, 0));
        offer_key(make_key('1, 0, 0));
        offer_key(make_key(2, 2, 2));
        offer_key(make_key(3, 3, 2));
        offer_key(make_key('1, '1, 2));
        offer_key(make_key(2, 2, 65537));
        offer_key(build_key('1, 1, '1));
        offer_key(build_key('1, 200, $urandom));
        offer_key(build_key(32'h8000_0000, 1, 0));
        offer_key(build_key(32'h7FFF_FFFF, 3, '1));
        offer_key(make_key(65537, 65539, 3));
    endtask

    // output held off long enough that the block fills and stalls its input
    task automatic test_stalled_output();
        sender_gaps  = 1'b0;
        hold_request = 3000;
        repeat (6)
            offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(2, 40)));
        sender_gaps = 1'b1;
    endtask

    // sender pauses until every result is back
    task automatic test_drained_pause();
        repeat (4)
            offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(2, 200)));
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (4)
            offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(2, 200)));
    endtask

    // sender and receiver with no idling on either side
    task automatic test_streaming_keys();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (16)
            offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(1, 60)));
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // mostly short searches, some large exponents with a known short search
    task automatic test_random_keys();
        int unsigned sel;
        repeat (52)
        begin
            sel = $urandom_range(99);
            if (sel < 62)
                offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(1, 1023)));
            else if (sel < 90)
                offer_key(build_key($urandom_range(32'hFFFF_FFFF, 2),
                                    $urandom_range(1, 300), pick_prime()));
            else if (sel < 95)
                offer_key(make_key(pick_prime(), pick_prime(), $urandom_range(2, 65535)));
            else
                offer_key(make_key(pick_prime(), pick_prime(), 65537));
        end
    endtask

    // receiver: random idling plus requested hold-off
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(99) < 24)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        key_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_keys.size() == 0)
                report_mismatch("result with no request", m_tdata, '0);
            else
            begin
                want = expected_keys.pop_front();
                if (m_tdata !== want.d)
                    report_mismatch("exponent d", m_tdata, want.d);
                if (m_tuser !== want.status)
                    report_mismatch("status", D_W'(m_tuser), D_W'(want.status));
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_keys();
        test_stalled_output();
        test_drained_pause();
        test_streaming_keys();
        test_random_keys();
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (300)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rsaexp_pkg.sv
hdl/rsa_private_exponent_search_top.sv
tb/sv/tb_rsa_private_exponent_search_top.sv
